/* rtl/kkc_pkg.sv */
// ----------------------------------------------------------------------------
// kkc_pkg: shared types and constants for the k-clustering unit
// Holds the vertex limit, field widths, register indices and the structs that
// run between the sequencer, the find walker and the parent table.
// ----------------------------------------------------------------------------
package kkc_pkg;

	localparam int MAX_VERTICES = 1024;
	// Vertex fields are ten bits wide, so no more than 1024 vertices are usable.
	localparam int VTX_LIMIT    = (MAX_VERTICES < 1024) ? MAX_VERTICES : 1024;
	localparam int ADDR_W       = (VTX_LIMIT > 1) ? $clog2(VTX_LIMIT) : 1;
	localparam int VTX_W        = 10;
	localparam int CFG_W        = 11;

	localparam logic REG_VERTEX_COUNT    = 1'b0;
	localparam logic REG_CLUSTERS_WANTED = 1'b1;

	typedef logic [VTX_W-1:0]  vtx_t;
	typedef logic [CFG_W-1:0]  cfg_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic start;
		vtx_t vtx;
		cfg_t limit;
	} find_req_t;

	typedef struct packed {
		logic done;
		vtx_t root;
	} find_rsp_t;

	typedef struct packed {
		logic  rd_en;
		addr_t rd_addr;
	} mem_rd_t;

	typedef struct packed {
		logic  we;
		addr_t addr;
		vtx_t  data;
	} mem_wr_t;

	// Only vertices below the usable limit ever reach the table.
	function automatic addr_t to_addr(input vtx_t v);
		return v[ADDR_W-1:0];
	endfunction

endpackage

/* rtl/kkc_parent_mem.sv */
// ----------------------------------------------------------------------------
// kkc_parent_mem: union-find parent table
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kkc_parent_mem (
	input  logic            clk,
	input  kkc_pkg::mem_rd_t rd,
	input  kkc_pkg::mem_wr_t wr,
	output kkc_pkg::vtx_t    rd_data
);

	kkc_pkg::vtx_t mem [kkc_pkg::VTX_LIMIT];
	kkc_pkg::vtx_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.rd_en) begin
			rd_data_q <= mem[rd.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/kkc_find_unit.sv */
// ----------------------------------------------------------------------------
// kkc_find_unit: root walker
// Climbs the parent chain one table read per cycle until an entry points at
// itself; a vertex at or above the usable limit is its own root.
// ----------------------------------------------------------------------------
module kkc_find_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  kkc_pkg::find_req_t req,
	output kkc_pkg::find_rsp_t rsp,
	output kkc_pkg::mem_rd_t   rd,
	input  kkc_pkg::vtx_t      rd_data
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_WALK = 2'd1;
	localparam logic [1:0] F_HIT  = 2'd2;

	logic [1:0]    state_q;
	kkc_pkg::vtx_t cur_q;
	logic          walk_stop;
	logic          in_range;

	// Parents never sit above their child, so the chain ends where p >= v.
	assign walk_stop = (rd_data >= cur_q);
	assign in_range  = ({1'b0, req.vtx} < req.limit);

	always_comb begin
		rsp.done   = ((state_q == F_WALK) && walk_stop) || (state_q == F_HIT);
		rsp.root   = cur_q;
		rd.rd_en   = (req.start && in_range) || ((state_q == F_WALK) && !walk_stop);
		rd.rd_addr = req.start ? kkc_pkg::to_addr(req.vtx) : kkc_pkg::to_addr(rd_data);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else if (req.start) begin
			state_q <= in_range ? F_WALK : F_HIT;
		end else begin
			case (state_q)
				F_WALK: begin
					if (walk_stop) begin
						state_q <= F_IDLE;
					end
				end
				F_HIT:   state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			cur_q <= req.vtx;
		end else if ((state_q == F_WALK) && !walk_stop) begin
			cur_q <= rd_data;
		end
	end

endmodule

/* rtl/kruskal_k_clustering_unit.sv */
// ----------------------------------------------------------------------------
// kruskal_k_clustering_unit: k-clustering by Kruskal's method on union-find
// Edge offers join clusters until the required number of joins is made;
// queries return the smallest vertex of a vertex's cluster.
// ----------------------------------------------------------------------------
// Timing: a walk climbs the parent chain in the find unit, one table read per
// cycle; an edge walks vertex_a and then vertex_b on the shared walker, a query
// walks vertex_a alone, and each item then passes through S_EMIT.
// Throughput: one transaction at a time; the next is taken once the result
// sits in the output register. Reset: the parent table is swept back to
// self-pointers, all VTX_LIMIT entries (1024 by default), before in_ready rises.
// ----------------------------------------------------------------------------
module kruskal_k_clustering_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  kkc_pkg::cfg_t        cfg_data,
	// input item channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 func,
	input  kkc_pkg::vtx_t        vertex_a,
	input  kkc_pkg::vtx_t        vertex_b,
	// result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 merged,
	output logic                 done_res,
	output kkc_pkg::vtx_t        cluster_root,
	output kkc_pkg::vtx_t        joins_made
);

	// Sequencer states.
	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_FIND_A = 3'd2;
	localparam logic [2:0] S_FIND_B = 3'd3;
	localparam logic [2:0] S_FIND_Q = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;

	logic [2:0]             state_q;
	kkc_pkg::addr_t         clr_q;
	kkc_pkg::cfg_t          vertex_count_q;
	kkc_pkg::cfg_t          clusters_wanted_q;
	kkc_pkg::vtx_t          join_q;
	kkc_pkg::vtx_t          b_q;
	kkc_pkg::vtx_t          ra_q;
	logic                   res_merged_q;
	kkc_pkg::vtx_t          res_root_q;
	logic                   out_valid_q;
	logic                   out_merged_q;
	logic                   out_done_q;
	kkc_pkg::vtx_t          out_root_q;
	kkc_pkg::vtx_t          out_joins_q;

	kkc_pkg::cfg_t          n_lim;
	kkc_pkg::cfg_t          k_eff;
	kkc_pkg::cfg_t          req_joins;
	logic                   in_accept;
	logic                   eligible;
	logic                   join_ok;
	logic                   out_free;
	kkc_pkg::find_req_t     find_req;
	kkc_pkg::find_rsp_t     find_rsp;
	kkc_pkg::mem_rd_t       mem_rd;
	kkc_pkg::mem_wr_t       mem_wr;
	kkc_pkg::vtx_t          mem_rd_data;
	kkc_pkg::vtx_t          root_lo;
	kkc_pkg::vtx_t          root_hi;

	// Usable vertices are capped at the table depth; a target of zero counts as
	// one cluster, and a target at or above the vertex count needs no joins.
	always_comb begin
		n_lim     = (vertex_count_q > kkc_pkg::cfg_t'(kkc_pkg::VTX_LIMIT)) ?
		            kkc_pkg::cfg_t'(kkc_pkg::VTX_LIMIT) : vertex_count_q;
		k_eff     = (clusters_wanted_q == '0) ? kkc_pkg::cfg_t'(1) : clusters_wanted_q;
		req_joins = (n_lim > k_eff) ? (n_lim - k_eff) : '0;
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_accept = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// An edge is worked only while joins are still owed and both ends are
	// usable vertices; any other item just walks vertex_a to its root.
	assign eligible = !func && ({1'b0, join_q} < req_joins) &&
	                  ({1'b0, vertex_a} < n_lim) && ({1'b0, vertex_b} < n_lim);

	// The smaller root becomes the label of the joined cluster.
	assign root_lo = (find_rsp.root < ra_q) ? find_rsp.root : ra_q;
	assign root_hi = (find_rsp.root < ra_q) ? ra_q : find_rsp.root;
	assign join_ok = (state_q == S_FIND_B) && find_rsp.done && (find_rsp.root != ra_q);

	always_comb begin
		find_req.start = in_accept || ((state_q == S_FIND_A) && find_rsp.done);
		find_req.vtx   = (state_q == S_FIND_A) ? b_q : vertex_a;
		find_req.limit = n_lim;
	end

	// The table is written by the post-reset sweep or by a join, never both.
	always_comb begin
		if (state_q == S_CLEAR) begin
			mem_wr.we   = 1'b1;
			mem_wr.addr = clr_q;
			mem_wr.data = kkc_pkg::vtx_t'(clr_q);
		end else begin
			mem_wr.we   = join_ok;
			mem_wr.addr = kkc_pkg::to_addr(root_hi);
			mem_wr.data = root_lo;
		end
	end

	kkc_find_unit u_find (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (find_req),
		.rsp     (find_rsp),
		.rd      (mem_rd),
		.rd_data (mem_rd_data)
	);

	kkc_parent_mem u_mem (
		.clk     (clk),
		.rd      (mem_rd),
		.wr      (mem_wr),
		.rd_data (mem_rd_data)
	);

	// Control state: sequencer, sweep counter, registers, join count and the
	// valid flag of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_CLEAR;
			clr_q             <= '0;
			vertex_count_q    <= kkc_pkg::cfg_t'(1024);
			clusters_wanted_q <= kkc_pkg::cfg_t'(1);
			join_q            <= '0;
			out_valid_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					kkc_pkg::REG_VERTEX_COUNT:    vertex_count_q    <= cfg_data;
					kkc_pkg::REG_CLUSTERS_WANTED: clusters_wanted_q <= cfg_data;
					default: ;
				endcase
			end

			// A new result loads the output register as the old one leaves.
			if ((state_q == S_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == kkc_pkg::addr_t'(kkc_pkg::VTX_LIMIT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_accept) begin
						state_q <= eligible ? S_FIND_A : S_FIND_Q;
					end
				end
				S_FIND_A: begin
					if (find_rsp.done) begin
						state_q <= S_FIND_B;
					end
				end
				S_FIND_B: begin
					if (find_rsp.done) begin
						state_q <= S_EMIT;
						if (join_ok) begin
							join_q <= join_q + 1'b1;
						end
					end
				end
				S_FIND_Q: begin
					if (find_rsp.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			b_q <= vertex_b;
		end
		if ((state_q == S_FIND_A) && find_rsp.done) begin
			ra_q <= find_rsp.root;
		end
		if ((state_q == S_FIND_B) && find_rsp.done) begin
			res_merged_q <= join_ok;
			res_root_q   <= join_ok ? root_lo : ra_q;
		end
		if ((state_q == S_FIND_Q) && find_rsp.done) begin
			res_merged_q <= 1'b0;
			res_root_q   <= find_rsp.root;
		end
		if ((state_q == S_EMIT) && out_free) begin
			out_merged_q <= res_merged_q;
			out_done_q   <= ({1'b0, join_q} >= req_joins);
			out_root_q   <= res_root_q;
			out_joins_q  <= join_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign merged       = out_merged_q;
	assign done_res     = out_done_q;
	assign cluster_root = out_root_q;
	assign joins_made   = out_joins_q;

endmodule
